>>> design/cts_pkg.sv
// Shared types and constants for the cron tick scheduler.
package cts_pkg;

  // Request type codes on the input channel.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Command kinds after classification.
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_SKIP = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Configuration register map.
  localparam int unsigned  ADDR_W          = 3;
  localparam logic [0:0]   REG_ENTRY_COUNT = 1'b0;

  // Depth of the decoupling queues.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [5:0]  STARTED_MAX = 6'h3F;
  localparam logic [15:0] RUNS_MAX    = 16'hFFFF;
  localparam logic [31:0] TOTAL_MAX   = 32'hFFFF_FFFF;

  // Time pattern (load) or current time (tick) plus run length.
  typedef struct packed {
    logic [6:0]  minute;
    logic [5:0]  hour;
    logic [5:0]  date;
    logic [4:0]  month;
    logic [3:0]  dow;
    logic [15:0] run;
  } sched_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] idx;
    sched_t     data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] runs;
  } dyn_t;

  typedef struct packed {
    logic [5:0]  started;
    logic [31:0] total;
    logic [5:0]  peak;
    logic [4:0]  champ_idx;
    logic [15:0] champ_runs;
  } res_t;

  // Handshake between the command queue and the sequencer.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

endpackage

>>> design/cron_tick_scheduler.sv
// Top level of the cron tick scheduler: config register, front, sequencer, result queue.
//
// Usage:
//   Input channel (push/full): each beat is a load (req_type 0) that writes one schedule
//   entry and clears its run state, or a tick (req_type 1) that carries the current time.
//   Result channel (empty/pop): exactly one result beat per input beat, in order.
//   Config port (APB style, pready always high): entry_count at byte address 0 sets how
//   many entries a tick walks and the champion scan covers; write it only while idle.
// Sequencing:
//   For each beat the sequencer takes the command (and writes the entry on a load), reads
//   n = min(entry_count, MAX_ENTRIES) entries from the entry memories, retires the last
//   entry and posts the result; it takes the next command only after posting the result.
//   The single read port of the entry memories sets the walk rate: one entry per cycle.
// Reset:
//   Clears both queues, the active flags and the valid bits of the run-state memory (so
//   remaining and run counts read as zero), the start total, the peak and entry_count.
// Stalls:
//   A two-deep command queue keeps accepting while the sequencer works; the sequencer
//   starts a command only when the result queue has room, so a stalled receiver holds
//   results in place and backs up into full on the input side.
module cron_tick_scheduler #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       push,
  output logic                       full,
  input  logic                       in_req_type,
  input  logic [4:0]                 in_entry_index,
  input  logic signed [6:0]          in_minute,
  input  logic signed [5:0]          in_hour,
  input  logic signed [5:0]          in_date,
  input  logic signed [4:0]          in_month,
  input  logic signed [3:0]          in_day_of_week,
  input  logic [15:0]                in_run_minutes,
  // result channel
  output logic                       empty,
  input  logic                       pop,
  output logic [5:0]                 out_started_now,
  output logic [31:0]                out_total_starts,
  output logic [5:0]                 out_peak_started,
  output logic [4:0]                 out_champion_index,
  output logic [15:0]                out_champion_runs,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cts_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import cts_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [5:0]    entry_count_r, entry_count_nxt;
  logic [CW-1:0] live_n;
  logic          cfg_we;
  cmd_beat_t     cmd_beat;
  logic          cmd_take;
  logic          res_full;
  logic          res_push;
  res_t          res_new;
  res_t          res_head;

  // Register write lands on the access phase; address bits below the word are ignored.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[ADDR_W-1:2] == REG_ENTRY_COUNT);
  assign entry_count_nxt = cfg_we ? pwdata[5:0] : entry_count_r;

  always_comb begin
    if (paddr[ADDR_W-1:2] == REG_ENTRY_COUNT) begin
      prdata = {26'd0, entry_count_r};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else begin
      entry_count_r <= entry_count_nxt;
    end
  end

  // Clamp the walk length to the entries that exist.
  always_comb begin
    if (32'(entry_count_r) > MAX_ENTRIES) begin
      live_n = CW'(MAX_ENTRIES);
    end else begin
      live_n = CW'(entry_count_r);
    end
  end

  cts_front #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_req_type    (in_req_type),
    .in_entry_index (in_entry_index),
    .in_minute      (in_minute),
    .in_hour        (in_hour),
    .in_date        (in_date),
    .in_month       (in_month),
    .in_day_of_week (in_day_of_week),
    .in_run_minutes (in_run_minutes),
    .cmd_out        (cmd_beat),
    .cmd_take       (cmd_take)
  );

  cts_back #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .live_n   (live_n),
    .cmd_in   (cmd_beat),
    .cmd_take (cmd_take),
    .res_full (res_full),
    .res_push (res_push),
    .res_out  (res_new)
  );

  cts_out_queue u_out_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_in   (res_new),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .res_head (res_head)
  );

  assign out_started_now    = res_head.started;
  assign out_total_starts   = res_head.total;
  assign out_peak_started   = res_head.peak;
  assign out_champion_index = res_head.champ_idx;
  assign out_champion_runs  = res_head.champ_runs;

endmodule

>>> design/cts_front.sv
// Input side: accept beats, classify them and hold them in a short command queue.
module cts_front #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic                in_req_type,
  input  logic [4:0]          in_entry_index,
  input  logic signed [6:0]   in_minute,
  input  logic signed [5:0]   in_hour,
  input  logic signed [5:0]   in_date,
  input  logic signed [4:0]   in_month,
  input  logic signed [3:0]   in_day_of_week,
  input  logic [15:0]         in_run_minutes,
  output cts_pkg::cmd_beat_t  cmd_out,
  input  logic                cmd_take
);
  import cts_pkg::*;

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t              cmd_new;
  logic              do_push, do_pop;

  // Classify: out-of-range loads only rescan the champion.
  always_comb begin
    cmd_new.idx         = in_entry_index;
    cmd_new.data.minute = in_minute;
    cmd_new.data.hour   = in_hour;
    cmd_new.data.date   = in_date;
    cmd_new.data.month  = in_month;
    cmd_new.data.dow    = in_day_of_week;
    cmd_new.data.run    = in_run_minutes;
    if (in_req_type == REQ_TICK) begin
      cmd_new.kind = CMD_TICK;
    end else if (32'(in_entry_index) < MAX_ENTRIES) begin
      cmd_new.kind = CMD_LOAD;
    end else begin
      cmd_new.kind = CMD_SKIP;
    end
  end

  assign full          = (cnt_r == QCNT_W'(QDEPTH));
  assign do_push       = push && !full;
  assign do_pop        = cmd_take && (cnt_r != '0);
  assign cmd_out.valid = (cnt_r != '0);
  assign cmd_out.cmd   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cmd_new;
    end
  end

endmodule

>>> design/cts_back.sv
// Sequencer: writes entries, walks them on ticks and tracks the champion.
module cts_back #(
  parameter int MAX_ENTRIES = 32,
  parameter int IW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CW-1:0]      live_n,
  input  cts_pkg::cmd_beat_t cmd_in,
  output logic               cmd_take,
  input  logic               res_full,
  output logic               res_push,
  output cts_pkg::res_t      res_out
);
  import cts_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             st_r, st_nxt;
  cmd_t                   cur_r, cur_nxt;
  logic [CW-1:0]          rd_cnt_r, rd_cnt_nxt;
  logic                   s1_v_r, s1_v_nxt;
  logic [IW-1:0]          s1_idx_r, s1_idx_nxt;
  logic [MAX_ENTRIES-1:0] act_r, act_nxt;
  logic [MAX_ENTRIES-1:0] vld_r, vld_nxt;
  logic [5:0]             started_r, started_nxt;
  logic [31:0]            total_r, total_nxt;
  logic [5:0]             peak_r, peak_nxt;
  logic [IW-1:0]          best_idx_r, best_idx_nxt;
  logic [15:0]            best_runs_r, best_runs_nxt;

  sched_t sched_mem_r [MAX_ENTRIES];
  dyn_t   dyn_mem_r   [MAX_ENTRIES];
  sched_t sched_q_r;
  dyn_t   dyn_q_r;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          ld_we;
  logic [IW-1:0] ld_addr;
  logic          dyn_we;
  dyn_t          dyn_wr;
  dyn_t          dyn_old;
  logic          act_old;
  logic          match;

  assign ld_addr = IW'(cmd_in.cmd.idx);
  assign rd_addr = rd_cnt_r[IW-1:0];
  assign dyn_old = vld_r[s1_idx_r] ? dyn_q_r : '0;
  assign act_old = act_r[s1_idx_r];

  always_comb begin
    match = ((sched_q_r.minute == cur_r.data.minute) || (&sched_q_r.minute)) &&
            ((sched_q_r.hour   == cur_r.data.hour)   || (&sched_q_r.hour))   &&
            ((sched_q_r.date   == cur_r.data.date)   || (&sched_q_r.date))   &&
            ((sched_q_r.month  == cur_r.data.month)  || (&sched_q_r.month))  &&
            ((sched_q_r.dow    == cur_r.data.dow)    || (&sched_q_r.dow));
  end

  always_comb begin
    st_nxt        = st_r;
    cur_nxt       = cur_r;
    rd_cnt_nxt    = rd_cnt_r;
    s1_v_nxt      = 1'b0;
    s1_idx_nxt    = s1_idx_r;
    act_nxt       = act_r;
    vld_nxt       = vld_r;
    started_nxt   = started_r;
    total_nxt     = total_r;
    peak_nxt      = peak_r;
    best_idx_nxt  = best_idx_r;
    best_runs_nxt = best_runs_r;
    cmd_take      = 1'b0;
    res_push      = 1'b0;
    rd_en         = 1'b0;
    ld_we         = 1'b0;
    dyn_we        = 1'b0;
    dyn_wr        = dyn_old;

    case (st_r)
      ST_IDLE: begin
        if (cmd_in.valid && !res_full) begin
          cmd_take      = 1'b1;
          cur_nxt       = cmd_in.cmd;
          rd_cnt_nxt    = '0;
          started_nxt   = '0;
          best_idx_nxt  = '0;
          best_runs_nxt = '0;
          st_nxt        = ST_WALK;
          if (cmd_in.cmd.kind == CMD_LOAD) begin
            ld_we            = 1'b1;
            act_nxt[ld_addr] = 1'b0;
            vld_nxt[ld_addr] = 1'b0;
          end
        end
      end
      ST_WALK: begin
        // Issue the next read while the previous entry is updated.
        if (rd_cnt_r < live_n) begin
          rd_en      = 1'b1;
          s1_v_nxt   = 1'b1;
          s1_idx_nxt = rd_addr;
          rd_cnt_nxt = CW'(rd_cnt_r + 1'b1);
        end else begin
          // The last entry, if any, retires in this cycle.
          st_nxt = ST_DONE;
        end
        if (s1_v_r) begin
          if (cur_r.kind == CMD_TICK) begin
            dyn_we            = 1'b1;
            vld_nxt[s1_idx_r] = 1'b1;
            if (!act_old && match) begin
              act_nxt[s1_idx_r] = 1'b1;
              dyn_wr.rem = (sched_q_r.run != '0) ? 16'(sched_q_r.run - 1'b1) : '0;
              if (dyn_old.runs != RUNS_MAX) begin
                dyn_wr.runs = 16'(dyn_old.runs + 1'b1);
              end
              if (total_r != TOTAL_MAX) begin
                total_nxt = 32'(total_r + 1'b1);
              end
              if (started_r != STARTED_MAX) begin
                started_nxt = 6'(started_r + 1'b1);
              end
            end else if (act_old && (dyn_old.rem == '0)) begin
              act_nxt[s1_idx_r] = 1'b0;
            end else if (act_old) begin
              dyn_wr.rem = 16'(dyn_old.rem - 1'b1);
            end
          end
          // Strict compare keeps the lowest index on a tie.
          if (dyn_wr.runs > best_runs_r) begin
            best_runs_nxt = dyn_wr.runs;
            best_idx_nxt  = s1_idx_r;
          end
        end
      end
      ST_DONE: begin
        res_push = 1'b1;
        if (started_r > peak_r) begin
          peak_nxt = started_r;
        end
        st_nxt = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_out.started    = started_r;
    res_out.total      = total_r;
    res_out.peak       = (started_r > peak_r) ? started_r : peak_r;
    res_out.champ_idx  = 5'(best_idx_r);
    res_out.champ_runs = best_runs_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      s1_v_r  <= 1'b0;
      act_r   <= '0;
      vld_r   <= '0;
      total_r <= '0;
      peak_r  <= '0;
    end else begin
      st_r    <= st_nxt;
      s1_v_r  <= s1_v_nxt;
      act_r   <= act_nxt;
      vld_r   <= vld_nxt;
      total_r <= total_nxt;
      peak_r  <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    rd_cnt_r    <= rd_cnt_nxt;
    s1_idx_r    <= s1_idx_nxt;
    started_r   <= started_nxt;
    best_idx_r  <= best_idx_nxt;
    best_runs_r <= best_runs_nxt;
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      sched_mem_r[ld_addr] <= cmd_in.cmd.data;
    end
    if (dyn_we) begin
      dyn_mem_r[s1_idx_r] <= dyn_wr;
    end
    if (rd_en) begin
      sched_q_r <= sched_mem_r[rd_addr];
      dyn_q_r   <= dyn_mem_r[rd_addr];
    end
  end

endmodule

>>> design/cts_out_queue.sv
// Result queue: holds finished results until the receiver pops them.
module cts_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_push,
  input  cts_pkg::res_t res_in,
  output logic          res_full,
  output logic          empty,
  input  logic          pop,
  output cts_pkg::res_t res_head
);
  import cts_pkg::*;

  res_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign res_full = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;
  assign res_head = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= res_in;
    end
  end

endmodule

>>> design/cts_checker.sv
// Port-level checks on the cron tick scheduler, bound to the top level.
module cts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [5:0]  out_started_now,
  input logic [31:0] out_total_starts,
  input logic [5:0]  out_peak_started,
  input logic [15:0] out_champion_runs
);

  // Reset drains the result queue.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // A result that is not popped keeps its started count, total and champion runs on the ports.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_total_starts) &&
                          $stable(out_started_now) && $stable(out_champion_runs)))
    else $error("waiting result changed");

  // The peak carried with a result covers that result's own start count.
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_peak_started >= out_started_now))
    else $error("peak below started count");

  // The running total includes the starts of the same tick.
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_total_starts >= 32'(out_started_now)))
    else $error("total below started count");

endmodule

bind cron_tick_scheduler cts_checker u_cts_checker (.*);

>>> dv/tb_cron_tick_scheduler.sv
// Testbench for the cron tick scheduler: queued stimulus, in-order result checking, APB setup.
module tb_cron_tick_scheduler;
  import cts_pkg::*;

  localparam int NUM_ENTRIES  = 32;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int LONG_STALL   = 600;
  localparam int PHASE_BEATS  = 88;
  localparam int REPORT_LIMIT = 10;

  // One input beat, laid out as on the input ports.
  typedef struct packed {
    logic       req_type;
    logic [4:0] entry_index;
    logic [6:0] minute;
    logic [5:0] hour;
    logic [5:0] date;
    logic [4:0] month;
    logic [3:0] dow;
    logic [15:0] run;
  } sched_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              push = 1'b0;
  logic              full;
  logic              in_req_type = 1'b0;
  logic [4:0]        in_entry_index = '0;
  logic signed [6:0] in_minute = '0;
  logic signed [5:0] in_hour = '0;
  logic signed [5:0] in_date = '0;
  logic signed [4:0] in_month = '0;
  logic signed [3:0] in_day_of_week = '0;
  logic [15:0]       in_run_minutes = '0;

  logic        empty;
  logic        pop = 1'b0;
  logic [5:0]  out_started_now;
  logic [31:0] out_total_starts;
  logic [5:0]  out_peak_started;
  logic [4:0]  out_champion_index;
  logic [15:0] out_champion_runs;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  cron_tick_scheduler #(.MAX_ENTRIES(NUM_ENTRIES)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_req_type       (in_req_type),
    .in_entry_index    (in_entry_index),
    .in_minute         (in_minute),
    .in_hour           (in_hour),
    .in_date           (in_date),
    .in_month          (in_month),
    .in_day_of_week    (in_day_of_week),
    .in_run_minutes    (in_run_minutes),
    .empty             (empty),
    .pop               (pop),
    .out_started_now   (out_started_now),
    .out_total_starts  (out_total_starts),
    .out_peak_started  (out_peak_started),
    .out_champion_index(out_champion_index),
    .out_champion_runs (out_champion_runs),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Shadow copy of the scheduler state.
  sched_req_t  entry_pat  [NUM_ENTRIES];
  logic        entry_busy [NUM_ENTRIES];
  logic [15:0] entry_left [NUM_ENTRIES];
  logic [15:0] entry_hits [NUM_ENTRIES];
  logic [31:0] start_sum;
  logic [5:0]  start_peak;
  int unsigned scan_len;

  sched_req_t feed_q[$];     // beats waiting for the driver
  res_t       due_q[$];      // predicted result beats, oldest first
  sched_req_t cur_beat;      // beat now on the input ports
  logic       beat_taken = 1'b0;

  int  err_cnt = 0;
  int  results_seen = 0;
  int  cycle_cnt = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  stall_left = 0;
  logic stall_armed = 1'b0;
  logic calm_tail = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Advance the shadow state by one beat and return the result it should produce.
  function automatic res_t advance_schedule(sched_req_t r);
    res_t        e;
    logic [5:0]  started;
    logic [4:0]  best_i;
    logic [15:0] best_r;
    logic        hit;
    sched_req_t  p;
    int          n;
    n = (scan_len > NUM_ENTRIES) ? NUM_ENTRIES : int'(scan_len);
    started = '0;
    if (r.req_type == REQ_LOAD) begin
      // Rewrite the entry and clear its run state.
      entry_pat[r.entry_index]  = r;
      entry_busy[r.entry_index] = 1'b0;
      entry_left[r.entry_index] = '0;
      entry_hits[r.entry_index] = '0;
    end else begin
      for (int i = 0; i < n; i++) begin
        p = entry_pat[i];
        hit = (p.minute == r.minute || p.minute == '1) &&
              (p.hour == r.hour || p.hour == '1) &&
              (p.date == r.date || p.date == '1) &&
              (p.month == r.month || p.month == '1) &&
              (p.dow == r.dow || p.dow == '1);
        if (!entry_busy[i] && hit) begin
          entry_busy[i] = 1'b1;
          entry_left[i] = (p.run == 16'd0) ? 16'd0 : p.run - 16'd1;
          if (entry_hits[i] != RUNS_MAX) entry_hits[i] = entry_hits[i] + 16'd1;
          if (start_sum != TOTAL_MAX) start_sum = start_sum + 32'd1;
          if (started != STARTED_MAX) started = started + 6'd1;
        end else if (entry_busy[i] && entry_left[i] == 16'd0) begin
          // Finished entries go idle and may not restart on this tick.
          entry_busy[i] = 1'b0;
        end else if (entry_busy[i]) begin
          entry_left[i] = entry_left[i] - 16'd1;
        end
      end
      if (started > start_peak) start_peak = started;
    end
    // Lowest index wins a tie on run count.
    best_i = '0;
    best_r = '0;
    for (int i = 0; i < n; i++) begin
      if (entry_hits[i] > best_r) begin
        best_r = entry_hits[i];
        best_i = 5'(i);
      end
    end
    e.started    = started;
    e.total      = start_sum;
    e.peak       = start_peak;
    e.champ_idx  = best_i;
    e.champ_runs = best_r;
    return e;
  endfunction

  function automatic sched_req_t mk_beat(logic kind, int idx, int mi, int hr, int dt, int mo,
                                         int dw, int run);
    sched_req_t r;
    r.req_type    = kind;
    r.entry_index = 5'(idx);
    r.minute      = 7'(mi);
    r.hour        = 6'(hr);
    r.date        = 6'(dt);
    r.month       = 5'(mo);
    r.dow         = 4'(dw);
    r.run         = 16'(run);
    return r;
  endfunction

  // Pattern value: wildcard half the time, else a small clock value, rarely anything in range.
  function automatic int pick_pattern(int hi);
    int c;
    c = $urandom_range(0, 9);
    if (c < 5) return -1;
    if (c < 9) return $urandom_range(0, 2);
    return $urandom_range(0, hi);
  endfunction

  // Tick value: mostly from the same small set so that entries fire, sometimes noise.
  function automatic int pick_now(int hi);
    int c;
    c = $urandom_range(0, 9);
    if (c < 8) return $urandom_range(0, 2);
    if (c == 8) return -1;
    return $urandom_range(0, hi);
  endfunction

  function automatic sched_req_t random_request();
    int c;
    int run;
    logic kind;
    c = $urandom_range(0, 9);
    kind = (c < 7) ? REQ_TICK : REQ_LOAD;
    c = $urandom_range(0, 9);
    if (c < 6) run = $urandom_range(1, 4);
    else if (c == 6) run = 0;
    else if (c == 7) run = 65535;
    else run = $urandom_range(0, 65535);
    if (kind == REQ_TICK)
      return mk_beat(kind, $urandom_range(0, 31), pick_now(59), pick_now(23), pick_now(31),
                     pick_now(11), pick_now(6), run);
    return mk_beat(kind, $urandom_range(0, 31), pick_pattern(59), pick_pattern(23),
                   pick_pattern(31), pick_pattern(11), pick_pattern(6), run);
  endfunction

  // One APB transfer: setup cycle, then access until pready.
  task automatic cfg_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_ENTRY_COUNT, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_entry_count(input int n);
    logic [31:0] rd;
    cfg_access(1'b1, 32'(n), rd);
    scan_len = n;
    cfg_access(1'b0, '0, rd);
    if (rd !== 32'(n)) begin
      err_cnt++;
      if (err_cnt <= REPORT_LIMIT)
        $display("entry_count readback: expected %0d, got %0d", n, rd);
    end
  endtask

  // Hold until every queued beat is in and every predicted result has come out.
  task automatic wait_drained();
    while (feed_q.size() != 0 || push) @(posedge clk);
    while (due_q.size() != 0) @(posedge clk);
  endtask

  // Input side: predict every beat the block takes.
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      due_q.push_back(advance_schedule(cur_beat));
      beat_taken = 1'b1;
    end
  end

  // Input side: hold a beat until taken, otherwise idle in bursts or present the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (push && !beat_taken) begin
      // hold the current beat
    end else begin
      beat_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap = tx_gap - 1;
        push <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
        tx_gap = $urandom_range(1, 15) - 1;
        push <= 1'b0;
      end else if (feed_q.size() != 0) begin
        cur_beat = feed_q.pop_front();
        in_req_type    <= cur_beat.req_type;
        in_entry_index <= cur_beat.entry_index;
        in_minute      <= cur_beat.minute;
        in_hour        <= cur_beat.hour;
        in_date        <= cur_beat.date;
        in_month       <= cur_beat.month;
        in_day_of_week <= cur_beat.dow;
        in_run_minutes <= cur_beat.run;
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result side: compare each popped beat against the oldest prediction.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && pop && !empty) begin
      got = {out_started_now, out_total_starts, out_peak_started, out_champion_index,
             out_champion_runs};
      results_seen++;
      if (due_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= REPORT_LIMIT)
          $display("result beat with nothing pending: started %0d total %0d", got.started,
                   got.total);
      end else begin
        want = due_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= REPORT_LIMIT)
            $display("result %0d: expected started %0d total %0d peak %0d champ %0d/%0d, ",
                     results_seen, want.started, want.total, want.peak, want.champ_idx,
                     want.champ_runs,
                     "got started %0d total %0d peak %0d champ %0d/%0d",
                     got.started, got.total, got.peak, got.champ_idx, got.champ_runs);
        end
      end
    end
  end

  // Result side: one long stall on request, plus short random bursts of back-pressure.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      pop <= 1'b0;
    end else if (stall_armed) begin
      stall_armed = 1'b0;
      stall_left = LONG_STALL - 1;
      pop <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      pop <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
      rx_gap = $urandom_range(1, 15) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int plan[8];
    int n;
    plan = '{8, 32, 1, 0, -1, 31, -1, 32};
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      entry_pat[i]  = '0;
      entry_busy[i] = 1'b0;
      entry_left[i] = '0;
      entry_hits[i] = '0;
    end
    start_sum  = '0;
    start_peak = '0;
    scan_len   = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_entry_count(0);

    // No entries examined: ticks report a zero champion.
    feed_q.push_back(mk_beat(REQ_TICK, 0, -1, -1, -1, -1, -1, 0));
    feed_q.push_back(mk_beat(REQ_TICK, 31, 59, 23, 31, 11, 6, 65535));
    // Load the first entries with wildcards, extremes and a zero run length.
    feed_q.push_back(mk_beat(REQ_LOAD, 0, -1, -1, -1, -1, -1, 1));
    feed_q.push_back(mk_beat(REQ_LOAD, 1, -1, -1, -1, -1, -1, 0));
    feed_q.push_back(mk_beat(REQ_LOAD, 2, 59, 23, 31, 11, 6, 65535));
    feed_q.push_back(mk_beat(REQ_LOAD, 3, 0, -1, -1, -1, -1, 2));
    feed_q.push_back(mk_beat(REQ_LOAD, 4, -1, -1, -1, -1, -1, 3));
    feed_q.push_back(mk_beat(REQ_LOAD, 5, 0, 0, 0, 0, 0, 1));
    feed_q.push_back(mk_beat(REQ_LOAD, 6, 1, 2, 3, 4, 5, 2));
    feed_q.push_back(mk_beat(REQ_LOAD, 7, -1, 0, -1, 0, -1, 1));
    feed_q.push_back(mk_beat(REQ_LOAD, 31, 59, 23, 31, 11, 6, 65535));
    wait_drained();
    set_entry_count(8);

    // Start, stop without restart, count down, then restart on later ticks.
    feed_q.push_back(mk_beat(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));
    feed_q.push_back(mk_beat(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));
    feed_q.push_back(mk_beat(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));
    // A tick of all wildcards matches only wildcard patterns.
    feed_q.push_back(mk_beat(REQ_TICK, 31, -1, -1, -1, -1, -1, 65535));
    feed_q.push_back(mk_beat(REQ_TICK, 0, 59, 23, 31, 11, 6, 0));
    feed_q.push_back(mk_beat(REQ_TICK, 0, 1, 2, 3, 4, 5, 0));
    // Reloading clears the run count of a busy entry.
    feed_q.push_back(mk_beat(REQ_LOAD, 0, -1, -1, -1, -1, -1, 1));
    feed_q.push_back(mk_beat(REQ_TICK, 0, 1, 0, 2, 0, 1, 0));
    wait_drained();

    foreach (plan[p]) begin
      n = (plan[p] < 0) ? $urandom_range(0, NUM_ENTRIES) : plan[p];
      wait_drained();
      set_entry_count(n);
      // Fill the remaining entries before any wider scan can read them.
      if (p == 0) begin
        for (int i = 8; i < NUM_ENTRIES - 1; i++) begin
          cur_beat = random_request();
          cur_beat.req_type = REQ_LOAD;
          cur_beat.entry_index = 5'(i);
          feed_q.push_back(cur_beat);
        end
      end
      if (p == 1) stall_armed = 1'b1;
      if (p == $size(plan) - 1) calm_tail = 1'b1;
      for (int k = 0; k < PHASE_BEATS; k++) feed_q.push_back(random_request());
    end
    wait_drained();

    repeat (50) @(posedge clk);
    if (err_cnt == 0 && due_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
